FILE: src/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and constants of the character LCD bus write engine.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  localparam int GLYPH_SLOTS = 8;
  localparam int NUM_DIGITS  = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W   = 64;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 16;
  localparam int OUT_USER_W  = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 6;

  localparam logic [7:0] ROW1_OFFSET    = 8'h40;
  localparam logic [7:0] SET_DDRAM_CMD  = 8'h80;
  localparam logic [7:0] FUNC_SET_BASE  = 8'b0011_1000;
  localparam logic [7:0] DISP_CTRL_BASE = 8'b0000_1100;
  localparam logic [7:0] CLEAR_CMD      = 8'h01;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;

  typedef enum logic [2:0] {
    OP_DATA   = 3'd0,
    OP_CMD    = 3'd1,
    OP_NUMBER = 3'd2,
    OP_CURSOR = 3'd3,
    OP_INIT   = 3'd4,
    OP_GLYPH  = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_FOUR_BIT   = 3'd0,
    CFG_COLUMNS    = 3'd1,
    CFG_ROWS       = 3'd2,
    CFG_TWO_LINE   = 3'd3,
    CFG_LARGE_FONT = 3'd4,
    CFG_CURSOR     = 3'd5,
    CFG_BLINK      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic       four_bit;
    logic [5:0] column_count;
    logic [1:0] row_count;
    logic       two_line;
    logic       large_font;
    logic       cursor_shown;
    logic       cursor_blink;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    four_bit:     1'b0,
    column_count: 6'd16,
    row_count:    2'd2,
    two_line:     1'b1,
    large_font:   1'b0,
    cursor_shown: 1'b0,
    cursor_blink: 1'b0
  };

  typedef enum logic [1:0] {
    K_BYTES  = 2'd0,
    K_NUMBER = 2'd1,
    K_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [1:0]      last_idx;
    logic [2:0]      rs;
    logic [2:0][7:0] bytes;
    logic [31:0]     number;
  } job_t;

  function automatic logic [33:0] pow10(input logic [3:0] p);
    logic [33:0] w;
    case (p)
      4'd0:    w = 34'd1;
      4'd1:    w = 34'd10;
      4'd2:    w = 34'd100;
      4'd3:    w = 34'd1000;
      4'd4:    w = 34'd10000;
      4'd5:    w = 34'd100000;
      4'd6:    w = 34'd1000000;
      4'd7:    w = 34'd10000000;
      4'd8:    w = 34'd100000000;
      4'd9:    w = 34'd1000000000;
      default: w = 34'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/char_lcd_bus_write_engine_core.sv
// ----------------------------------------------------------------------------
// char_lcd_bus_write_engine_core
// Character LCD bus write engine: turns requests into register-select and
// bus value transfers for a 4-bit or 8-bit character display interface.
//
//   channel  direction  tdata                          tuser
//   in_      slave      byte_value number column row    opcode
//                       glyph_slot
//   out_     master     bus_value status               transfer register_select
//   cfg_     write      cfg_we / cfg_index / cfg_wdata, no read-back
//
// A request leaves the queue for the back end, which then gives one result
// per cycle while out_tready is high and no number is being converted; a
// number goes through its ten decades in the single compare and subtract unit.
// Reset is synchronous on rst_n; a two-entry job queue lets requests be
// accepted while earlier results are still stalled on the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_bus_write_engine_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [clcd_pkg::IN_DATA_W-1:0]     in_tdata,   // byte_value, number, column, row, glyph_slot
  input  wire logic [clcd_pkg::IN_USER_W-1:0]     in_tuser,   // opcode
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [clcd_pkg::OUT_DATA_W-1:0]         out_tdata,  // bus_value, status
  output logic [clcd_pkg::OUT_USER_W-1:0]         out_tuser,  // transfer, register_select
  output logic                                    out_tlast,
  input  wire logic                               cfg_we,
  input  wire logic [clcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [clcd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  clcd_pkg::cfg_t cfg_r;
  clcd_pkg::job_t push_job;
  clcd_pkg::job_t pop_job;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= clcd_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (clcd_pkg::cfg_idx_t'(cfg_index))
        clcd_pkg::CFG_FOUR_BIT:   cfg_r.four_bit     <= cfg_wdata[0];
        clcd_pkg::CFG_COLUMNS:    cfg_r.column_count <= cfg_wdata[5:0];
        clcd_pkg::CFG_ROWS:       cfg_r.row_count    <= cfg_wdata[1:0];
        clcd_pkg::CFG_TWO_LINE:   cfg_r.two_line     <= cfg_wdata[0];
        clcd_pkg::CFG_LARGE_FONT: cfg_r.large_font   <= cfg_wdata[0];
        clcd_pkg::CFG_CURSOR:     cfg_r.cursor_shown <= cfg_wdata[0];
        clcd_pkg::CFG_BLINK:      cfg_r.cursor_blink <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  clcd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  clcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  clcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: src/clcd_front.sv
// ----------------------------------------------------------------------------
// clcd_front
// Accepts requests, checks bounds and turns each known opcode into a job for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_front (
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [clcd_pkg::IN_DATA_W-1:0]   in_tdata,  // byte_value, number, column, row, glyph_slot
  input  wire logic [clcd_pkg::IN_USER_W-1:0]   in_tuser,  // opcode
  input  wire clcd_pkg::cfg_t                   cfg,
  input  wire logic                             q_full,
  output logic                                  push,
  output clcd_pkg::job_t                        push_job
);

  clcd_pkg::opcode_t op;
  logic [7:0]  byte_value;
  logic [31:0] number;
  logic [7:0]  column;
  logic [7:0]  row;
  logic [7:0]  glyph_slot;
  logic        pos_bad;
  logic        slot_bad;
  logic [7:0]  cursor_cmd;
  logic [7:0]  func_set;
  logic [7:0]  disp_ctrl;
  logic        known_op;

  assign op         = clcd_pkg::opcode_t'(in_tuser);
  assign byte_value = in_tdata[7:0];
  assign number     = in_tdata[39:8];
  assign column     = in_tdata[47:40];
  assign row        = in_tdata[55:48];
  assign glyph_slot = in_tdata[63:56];

  assign pos_bad  = (column >= {2'b00, cfg.column_count}) || (row >= {6'd0, cfg.row_count});
  assign slot_bad = glyph_slot >= 8'(clcd_pkg::GLYPH_SLOTS);

  assign cursor_cmd = clcd_pkg::SET_DDRAM_CMD |
                      ((row != 8'd0) ? (clcd_pkg::ROW1_OFFSET + column) : column);

  always_comb begin
    func_set = clcd_pkg::FUNC_SET_BASE;
    if (cfg.four_bit)   func_set[4] = 1'b0;
    if (!cfg.two_line)  func_set[3] = 1'b0;
    if (cfg.large_font) func_set[2] = 1'b1;
    disp_ctrl = clcd_pkg::DISP_CTRL_BASE;
    if (cfg.cursor_shown) disp_ctrl[1] = 1'b1;
    if (cfg.cursor_blink) disp_ctrl[0] = 1'b1;
  end

  always_comb begin
    push_job          = '0;
    push_job.kind     = clcd_pkg::K_BYTES;
    push_job.number   = number;
    known_op          = 1'b1;
    unique case (op)
      clcd_pkg::OP_DATA: begin
        push_job.bytes[0] = byte_value;
        push_job.rs[0]    = 1'b1;
      end
      clcd_pkg::OP_CMD: begin
        push_job.bytes[0] = byte_value;
      end
      clcd_pkg::OP_NUMBER: begin
        push_job.kind = clcd_pkg::K_NUMBER;
      end
      clcd_pkg::OP_CURSOR: begin
        if (pos_bad) push_job.kind = clcd_pkg::K_ERROR;
        push_job.bytes[0] = cursor_cmd;
      end
      clcd_pkg::OP_INIT: begin
        push_job.bytes[0] = func_set;
        push_job.bytes[1] = disp_ctrl;
        push_job.bytes[2] = clcd_pkg::CLEAR_CMD;
        push_job.last_idx = 2'd2;
      end
      clcd_pkg::OP_GLYPH: begin
        if (slot_bad || pos_bad) push_job.kind = clcd_pkg::K_ERROR;
        push_job.bytes[0] = cursor_cmd;
        push_job.bytes[1] = glyph_slot;
        push_job.rs[1]    = 1'b1;
        push_job.last_idx = 2'd1;
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready && known_op;

endmodule

`default_nettype wire

FILE: src/clcd_queue.sv
// ----------------------------------------------------------------------------
// clcd_queue
// Short job queue between the request front and the transfer back end.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire clcd_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output clcd_pkg::job_t      pop_job,
  output logic                empty
);

  clcd_pkg::job_t                 slots_r [clcd_pkg::QUEUE_DEPTH];
  logic [clcd_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [clcd_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [clcd_pkg::QCNT_W-1:0]    count_r;

  localparam logic [clcd_pkg::QPTR_W-1:0] PTR_LAST = clcd_pkg::QPTR_W'(clcd_pkg::QUEUE_DEPTH - 1);
  localparam logic [clcd_pkg::QCNT_W-1:0] CNT_FULL = clcd_pkg::QCNT_W'(clcd_pkg::QUEUE_DEPTH);

  assign full    = count_r == CNT_FULL;
  assign empty   = count_r == '0;
  assign pop_job = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: src/clcd_back.sv
// ----------------------------------------------------------------------------
// clcd_back
// Carries out jobs: decimal conversion, nibble splitting and the result
// register towards the bus side.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire clcd_pkg::cfg_t                    cfg,
  input  wire logic                              q_empty,
  input  wire clcd_pkg::job_t                    q_job,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [clcd_pkg::OUT_DATA_W-1:0]        out_tdata,  // bus_value, status
  output logic [clcd_pkg::OUT_USER_W-1:0]        out_tuser,  // transfer, register_select
  output logic                                   out_tlast
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ERR,
    S_SEND,
    S_CONV
  } state_t;

  state_t            state_r;
  clcd_pkg::kind_t   kind_r;
  logic [2:0][7:0]   bytes_r;
  logic [2:0]        rs_r;
  logic [1:0]        last_idx_r;
  logic [1:0]        idx_r;
  logic [7:0]        cur_byte_r;
  logic              cur_rs_r;
  logic              cur_last_r;
  logic              lo_phase_r;
  logic              pending_r;
  logic [31:0]       mag_r;
  logic [3:0]        pos_r;
  logic [1:0]        step_r;
  logic [3:0]        digit_r;
  logic              started_r;

  logic              out_valid_r;
  logic              out_xfer_r;
  logic              out_rs_r;
  logic [7:0]        out_bus_r;
  logic              out_status_r;
  logic              out_last_r;

  logic              slot_free;
  logic              emit;
  logic              send_fin;
  logic [1:0]        next_idx;
  logic [33:0]       weight;
  logic              ge;
  logic [3:0]        digit_new;
  logic [31:0]       mag_new;
  logic [31:0]       q_mag;

  assign slot_free = !out_valid_r || out_tready;
  assign emit      = slot_free && ((state_r == S_ERR) || (state_r == S_SEND));
  assign send_fin  = slot_free && (!cfg.four_bit || lo_phase_r);
  assign next_idx  = idx_r + 2'd1;
  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign q_mag     = q_job.number[31] ? (32'd0 - q_job.number) : q_job.number;

  // one restoring step per cycle: weights 8, 4, 2, 1 times the decade
  assign weight    = clcd_pkg::pow10(pos_r) << (2'd3 - step_r);
  assign ge        = {2'b00, mag_r} >= weight;
  assign digit_new = ge ? (digit_r | (4'b1000 >> step_r)) : digit_r;
  assign mag_new   = ge ? (mag_r - weight[31:0]) : mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (emit)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            kind_r     <= q_job.kind;
            bytes_r    <= q_job.bytes;
            rs_r       <= q_job.rs;
            last_idx_r <= q_job.last_idx;
            idx_r      <= 2'd0;
            lo_phase_r <= 1'b0;
            unique case (q_job.kind)
              clcd_pkg::K_BYTES: begin
                cur_byte_r <= q_job.bytes[0];
                cur_rs_r   <= q_job.rs[0];
                cur_last_r <= q_job.last_idx == 2'd0;
                state_r    <= S_SEND;
              end
              clcd_pkg::K_NUMBER: begin
                mag_r      <= q_mag;
                pos_r      <= 4'(clcd_pkg::NUM_DIGITS - 1);
                step_r     <= 2'd0;
                digit_r    <= 4'd0;
                started_r  <= 1'b0;
                cur_byte_r <= clcd_pkg::CHAR_MINUS;
                cur_rs_r   <= 1'b1;
                cur_last_r <= 1'b0;
                state_r    <= q_job.number[31] ? S_SEND : S_CONV;
              end
              clcd_pkg::K_ERROR: begin
                state_r <= S_ERR;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_xfer_r   <= 1'b0;
            out_rs_r     <= 1'b0;
            out_bus_r    <= 8'd0;
            out_status_r <= 1'b1;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_SEND: begin
          if (slot_free) begin
            out_xfer_r   <= 1'b1;
            out_rs_r     <= cur_rs_r;
            out_status_r <= 1'b0;
            if (!cfg.four_bit) begin
              out_bus_r  <= cur_byte_r;
              out_last_r <= cur_last_r;
            end else if (!lo_phase_r) begin
              out_bus_r  <= {cur_byte_r[7:4], 4'd0};
              out_last_r <= 1'b0;
              // first byte ever repeats its high nibble
              if (pending_r) pending_r  <= 1'b0;
              else           lo_phase_r <= 1'b1;
            end else begin
              out_bus_r  <= {cur_byte_r[3:0], 4'd0};
              out_last_r <= cur_last_r;
              lo_phase_r <= 1'b0;
            end
          end
          if (send_fin) begin
            if (cur_last_r) begin
              state_r <= S_IDLE;
            end else if (kind_r == clcd_pkg::K_NUMBER) begin
              state_r <= S_CONV;
            end else begin
              idx_r      <= next_idx;
              cur_byte_r <= bytes_r[next_idx];
              cur_rs_r   <= rs_r[next_idx];
              cur_last_r <= next_idx == last_idx_r;
            end
          end
        end
        S_CONV: begin
          mag_r <= mag_new;
          if (step_r == 2'd3) begin
            step_r  <= 2'd0;
            digit_r <= 4'd0;
            if (pos_r != 4'd0) pos_r <= pos_r - 4'd1;
            // leading zeros are dropped, the units digit always goes out
            if (digit_new != 4'd0 || started_r || pos_r == 4'd0) begin
              started_r  <= 1'b1;
              cur_byte_r <= clcd_pkg::CHAR_ZERO + {4'd0, digit_new};
              cur_rs_r   <= 1'b1;
              cur_last_r <= pos_r == 4'd0;
              state_r    <= S_SEND;
            end
          end else begin
            step_r  <= step_r + 2'd1;
            digit_r <= digit_new;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_status_r, out_bus_r};
  assign out_tuser  = {out_rs_r, out_xfer_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: src/clcd_sva.sv
// ----------------------------------------------------------------------------
// clcd_sva
// Port-level checks of the character LCD bus write engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_sva (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [clcd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic [clcd_pkg::OUT_USER_W-1:0]    out_tuser,
  input wire logic                               out_tlast,
  input wire logic                               cfg_we,
  input wire logic [clcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input wire logic [clcd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic nibble_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nibble_mode_r <= 1'b0;
    end else if (cfg_we && cfg_index == clcd_pkg::CFG_FOUR_BIT) begin
      nibble_mode_r <= cfg_wdata[0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata[8] &&
      out_tdata[7:0] == 8'd0 && !out_tuser[1])
    else $error("status-only result malformed");

  a_xfer_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tdata[8])
    else $error("transfer carries error status");

  a_nibble_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && nibble_mode_r |-> out_tdata[3:0] == 4'd0)
    else $error("low bits set in nibble mode");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind char_lcd_bus_write_engine_core clcd_sva u_sva (.*);

`default_nettype wire
